### src/lsm_pkg.sv
// Package for the Lucas sequence modular core.
// Request/result structs, status codes, shared ALU opcodes. No dependencies.
`default_nettype none
package lsm_pkg;

	localparam int unsigned FW = 64;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DISC_ZERO = 2'd1,
		ST_MOD_ZERO  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [FW-1:0] coef_p;
		logic signed [FW-1:0] coef_q;
		logic [FW-1:0]        seq_index;
		logic [FW-1:0]        modulus;
	} req_t;

	typedef struct packed {
		logic [FW-1:0] u_value;
		logic [FW-1:0] v_value;
		logic [1:0]    status;
	} res_t;

	// operations of the shared modular unit
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_SUB = 2'd1,
		OP_ADD = 2'd2,
		OP_RED = 2'd3
	} alu_op_t;

endpackage
`default_nettype wire

### src/lucas_sequence_mod_core.sv
// Top level of the Lucas sequence modular core: request capture, ladder
// sequencer and result strobe. Depends on lsm_pkg and lsm_alu.
//
// One request at a time: start is taken while busy is low, and the result
// appears on res with done high for exactly one cycle; the receiver cannot
// stall it. Each step runs on one shared modular unit, where a multiply or a
// reduction runs bit-serially and an add or subtract is computed directly;
// every step also passes through the sequencer's issue and next states. A zero
// bit of k costs five multiplies and five add/subtracts, a one bit six
// multiplies and three add/subtracts. The worst case is k all ones. Error
// requests answer in the cycle after start is taken.
`default_nettype none
module lucas_sequence_mod_core #(
	parameter int unsigned WIDTH = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire lsm_pkg::req_t req,
	output logic               busy,
	output logic               done,
	output lsm_pkg::res_t      res
);
	import lsm_pkg::*;

	localparam int unsigned CW = $clog2(WIDTH);

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_RED, S_INIT, S_TOP, S_RUN, S_ISSUE, S_WAIT, S_NEXT
	} state_t;

	// register file slots used as micro-step sources and destinations
	typedef enum logic [2:0] {
		R_QL, R_QH, R_UH, R_VL, R_VH, R_T, R_PM, R_QM
	} reg_t;

	state_t           state_q;
	logic [WIDTH-1:0] rf_q [8];
	logic [WIDTH-1:0] p_q, q_q, k_q, n_q;
	logic             p_neg_q, q_neg_q;
	logic [CW-1:0]    j_q, s_q;
	logic [1:0]       phase_q;   // 0 ladder, 1 combine, 2 tail
	logic [3:0]       uop_q;
	logic             redq_q;
	logic             alu_go;
	alu_op_t          alu_op;
	logic [WIDTH-1:0] alu_a, alu_b, alu_y;
	logic             alu_done;
	reg_t             dst_q;
	reg_t             sa, sb, sd;
	alu_op_t          sop;
	logic             slast;

	lsm_alu #(.WIDTH(WIDTH)) u_alu (
		.clk, .arst_n, .go(alu_go), .op(alu_op), .a(alu_a), .b(alu_b),
		.n(n_q), .done(alu_done), .y(alu_y)
	);

	// take the low WIDTH bits of P and Q and check for a zero discriminant
	logic [WIDTH-1:0] pin, qin, pmag;
	logic [WIDTH-1:0] half;
	logic             dz;
	always_comb begin
		pin  = req.coef_p[WIDTH-1:0];
		qin  = req.coef_q[WIDTH-1:0];
		pmag = pin[WIDTH-1] ? (~pin + 1'b1) : pin;
		half = pmag >> 1;
		dz   = !qin[WIDTH-1] && !pin[0] &&
			(half[WIDTH-1:WIDTH/2] == '0) &&
			(WIDTH'(half[WIDTH/2-1:0] * half[WIDTH/2-1:0]) == qin);
	end

	// micro-program: ladder bit one, bit zero, combine, tail
	wire kbit = k_q[j_q];
	always_comb begin
		sop = OP_MUL; sa = R_QL; sb = R_QH; sd = R_QL; slast = 1'b0;
		if (phase_q == 2'd0 && kbit) begin
			unique case (uop_q)
				4'd0: begin sa = R_QL; sb = R_QH; sd = R_QL; end
				4'd1: begin sa = R_QL; sb = R_QM; sd = R_QH; end
				4'd2: begin sa = R_UH; sb = R_VH; sd = R_UH; end
				4'd3: begin sa = R_QL; sb = R_PM; sd = R_T; end
				4'd4: begin sa = R_VH; sb = R_VL; sd = R_VL; end
				4'd5: begin sop = OP_SUB; sa = R_VL; sb = R_T; sd = R_VL; end
				4'd6: begin sop = OP_ADD; sa = R_QH; sb = R_QH; sd = R_T; end
				4'd7: begin sa = R_VH; sb = R_VH; sd = R_VH; end
				default: begin sop = OP_SUB; sa = R_VH; sb = R_T; sd = R_VH;
					slast = 1'b1; end
			endcase
		end else if (phase_q == 2'd0) begin
			unique case (uop_q)
				4'd0: begin sa = R_QL; sb = R_QH; sd = R_QL; end
				4'd1: begin sop = OP_ADD; sa = R_QL; sb = R_T; sd = R_QH; end
				4'd2: begin sa = R_UH; sb = R_VL; sd = R_UH; end
				4'd3: begin sop = OP_SUB; sa = R_UH; sb = R_QL; sd = R_UH; end
				4'd4: begin sa = R_QL; sb = R_PM; sd = R_T; end
				4'd5: begin sa = R_VH; sb = R_VL; sd = R_VH; end
				4'd6: begin sop = OP_SUB; sa = R_VH; sb = R_T; sd = R_VH; end
				4'd7: begin sop = OP_ADD; sa = R_QL; sb = R_QL; sd = R_T; end
				4'd8: begin sa = R_VL; sb = R_VL; sd = R_VL; end
				default: begin sop = OP_SUB; sa = R_VL; sb = R_T; sd = R_VL;
					slast = 1'b1; end
			endcase
		end else if (phase_q == 2'd1) begin
			unique case (uop_q)
				4'd0: begin sa = R_QL; sb = R_QH; sd = R_QL; end
				4'd1: begin sa = R_QL; sb = R_QM; sd = R_QH; end
				4'd2: begin sa = R_UH; sb = R_VL; sd = R_UH; end
				4'd3: begin sop = OP_SUB; sa = R_UH; sb = R_QL; sd = R_UH; end
				4'd4: begin sa = R_QL; sb = R_PM; sd = R_T; end
				4'd5: begin sa = R_VH; sb = R_VL; sd = R_VL; end
				4'd6: begin sop = OP_SUB; sa = R_VL; sb = R_T; sd = R_VL; end
				default: begin sa = R_QL; sb = R_QH; sd = R_QL; slast = 1'b1; end
			endcase
		end else begin
			unique case (uop_q)
				4'd0: begin sa = R_UH; sb = R_VL; sd = R_UH; end
				4'd1: begin sop = OP_ADD; sa = R_QL; sb = R_QL; sd = R_T; end
				4'd2: begin sa = R_VL; sb = R_VL; sd = R_VL; end
				4'd3: begin sop = OP_SUB; sa = R_VL; sb = R_T; sd = R_VL; end
				default: begin sa = R_QL; sb = R_QL; sd = R_QL; slast = 1'b1; end
			endcase
		end
	end

	// qh <- ql is done as ql + 0 with the T operand forced to zero (bit-zero step 1)
	always_comb begin
		alu_go = 1'b0;
		alu_op = sop;
		alu_a  = rf_q[sa];
		alu_b  = rf_q[sb];
		if (state_q == S_RED) begin
			alu_op = OP_RED;
			alu_a  = redq_q ? q_q : p_q;
			alu_go = 1'b1;
		end else if (state_q == S_ISSUE) begin
			alu_go = 1'b1;
			if (phase_q == 2'd0 && !kbit && uop_q == 4'd1) alu_b = '0;
		end
	end

	assign busy = (state_q != S_IDLE);

	// reduction of a signed value: magnitude mod n, then negate
	wire neg_sel = redq_q ? q_neg_q : p_neg_q;
	wire [WIDTH-1:0] red_fix = (neg_sel && alu_y != '0) ? (n_q - alu_y) : alu_y;
	wire [WIDTH-1:0] one_m = (n_q == WIDTH'(1)) ? '0 : WIDTH'(1);
	wire [WIDTH-1:0] two_m = (n_q == WIDTH'(1)) ? '0 :
		(n_q == WIDTH'(2)) ? '0 : WIDTH'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					k_q <= req.seq_index[WIDTH-1:0];
					n_q <= req.modulus[WIDTH-1:0];
					res.u_value <= '0;
					res.v_value <= '0;
					if (dz) begin
						res.status <= ST_DISC_ZERO; done <= 1'b1;
					end else if (req.modulus[WIDTH-1:0] == '0) begin
						res.status <= ST_MOD_ZERO; done <= 1'b1;
					end else begin
						res.status <= ST_OK;
						// magnitudes go to the reducer, signs kept aside
						p_q <= pin[WIDTH-1] ? (~pin + 1'b1) : pin;
						q_q <= qin[WIDTH-1] ? (~qin + 1'b1) : qin;
						p_neg_q <= pin[WIDTH-1];
						q_neg_q <= qin[WIDTH-1];
						state_q <= S_PREP;
					end
					redq_q <= 1'b0;
				end
				S_PREP: begin
					if (k_q == '0) begin
						res.v_value <= FW'(two_m); done <= 1'b1; state_q <= S_IDLE;
					end else state_q <= S_RED;
				end
				S_RED: state_q <= S_INIT;
				S_INIT: if (alu_done) begin
					if (!redq_q) begin
						rf_q[R_PM] <= red_fix; redq_q <= 1'b1; state_q <= S_RED;
					end else begin
						rf_q[R_QM] <= red_fix;
						rf_q[R_UH] <= one_m; rf_q[R_VL] <= two_m;
						rf_q[R_VH] <= rf_q[R_PM];
						rf_q[R_QL] <= one_m; rf_q[R_QH] <= one_m;
						j_q <= CW'(WIDTH-1); s_q <= '0;
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					// one bit a cycle: find top set bit, then lowest set bit
					if (!k_q[j_q]) j_q <= j_q - 1'b1;
					else if (!k_q[s_q]) s_q <= s_q + 1'b1;
					else begin
						uop_q <= '0;
						phase_q <= (j_q == s_q) ? 2'd1 : 2'd0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin dst_q <= sd; state_q <= S_WAIT; end
				S_WAIT: if (alu_done) begin
					rf_q[dst_q] <= alu_y;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					state_q <= S_ISSUE;
					if (!slast) uop_q <= uop_q + 1'b1;
					else begin
						uop_q <= '0;
						if (phase_q == 2'd0) begin
							j_q <= j_q - 1'b1;
							if (j_q - 1'b1 == s_q) phase_q <= 2'd1;
						end else if (phase_q == 2'd1 || j_q == '0) begin
							if (s_q == '0) begin
								res.u_value <= FW'(rf_q[R_UH]);
								res.v_value <= FW'(rf_q[R_VL]);
								done <= 1'b1; state_q <= S_IDLE;
							end else begin
								phase_q <= 2'd2; j_q <= s_q;
							end
						end else begin
							j_q <= j_q - 1'b1;
							if (j_q == CW'(1)) begin
								res.u_value <= FW'(rf_q[R_UH]);
								res.v_value <= FW'(rf_q[R_VL]);
								done <= 1'b1; state_q <= S_IDLE;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### src/lsm_alu.sv
// Shared modular arithmetic unit: bit-serial multiply, restoring reduction,
// add and subtract mod n computed directly on go. Depends on lsm_pkg.
`default_nettype none
module lsm_alu #(
	parameter int unsigned WIDTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire lsm_pkg::alu_op_t     op,
	input  wire logic [WIDTH-1:0]     a,
	input  wire logic [WIDTH-1:0]     b,
	input  wire logic [WIDTH-1:0]     n,
	output logic                      done,
	output logic [WIDTH-1:0]          y
);
	import lsm_pkg::*;

	localparam int unsigned CW = $clog2(WIDTH);

	logic [WIDTH-1:0] acc_q, a_q, b_q, n_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	alu_op_t          op_q;

	// modular add helper: x,z < n
	function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] z, input logic [WIDTH-1:0] m);
		logic [WIDTH-1:0] room;
		room = m - z;
		return (x >= room) ? (x - room) : (x + z);
	endfunction

	logic [WIDTH-1:0] dbl, mstep, rsh;
	logic [WIDTH:0]   rwide;

	always_comb begin
		dbl   = addm(acc_q, acc_q, n_q);
		mstep = b_q[WIDTH-1] ? addm(dbl, a_q, n_q) : dbl;
		// reduction: shift in next bit of a, subtract n if it fits
		rwide = {acc_q, a_q[WIDTH-1]};
		rsh   = (rwide >= {1'b0, n_q}) ? WIDTH'(rwide - {1'b0, n_q}) : rwide[WIDTH-1:0];
	end

	assign y = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				op_q <= op;
				a_q  <= a;
				b_q  <= b;
				n_q  <= n;
				cnt_q <= CW'(WIDTH-1);
				unique case (op)
					OP_SUB: begin
						acc_q <= (a >= b) ? (a - b) : (a + (n - b));
						done  <= 1'b1;
					end
					OP_ADD: begin
						acc_q <= addm(a, b, n);
						done  <= 1'b1;
					end
					default: begin
						acc_q <= '0;
						run_q <= 1'b1;
					end
				endcase
			end else if (run_q) begin
				if (op_q == OP_MUL) begin
					acc_q <= mstep;
					b_q   <= b_q << 1;
				end else begin
					acc_q <= rsh;
					a_q   <= a_q << 1;
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for lucas_sequence_mod_core: sends P, Q, k, n requests and compares
// U_k and V_k mod n and the status against a predictor built on lsm_pkg types.
// Depends on lsm_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import lsm_pkg::*;

	localparam int unsigned WATCH_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy, done;
	res_t res;

	res_t lucas_due[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit calm = 1'b0;

	lucas_sequence_mod_core #(.WIDTH(64)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .res(res)
	);

	always #4 clk = ~clk;

	// modular helpers, operands already in [0, n)
	function automatic logic [63:0] madd(logic [63:0] a, b, n);
		logic [63:0] room;
		room = n - b;
		return (a >= room) ? a - room : a + b;
	endfunction

	function automatic logic [63:0] msub(logic [63:0] a, b, n);
		return (a >= b) ? a - b : a + (n - b);
	endfunction

	function automatic logic [63:0] mmul(logic [63:0] a, b, n);
		logic [127:0] prod;
		prod = a * b;
		return 64'(prod % {64'd0, n});
	endfunction

	function automatic logic [63:0] mreduce(logic [63:0] v, n);
		logic [63:0] mag, r;
		mag = v[63] ? -v : v;
		r = mag % n;
		return (v[63] && r != 0) ? n - r : r;
	endfunction

	// true when P*P == 4Q over the integers
	function automatic bit disc_is_zero(logic [63:0] p, q);
		logic [63:0] mag, half;
		if (q[63] || p[0]) return 1'b0;
		mag = p[63] ? -p : p;
		half = mag >> 1;
		if (half > 64'hFFFF_FFFF) return 1'b0;
		return half * half == q;
	endfunction

	function automatic res_t lucas_predict(req_t r);
		res_t o;
		logic [63:0] p, q, k, n, pm, qm, uh, vl, vh, ql, qh, t;
		int top, tz, j;
		p = r.coef_p; q = r.coef_q; k = r.seq_index; n = r.modulus;
		o = '0;
		if (disc_is_zero(p, q)) begin
			o.status = ST_DISC_ZERO;
			return o;
		end
		if (n == 0) begin
			o.status = ST_MOD_ZERO;
			return o;
		end
		o.status = ST_OK;
		if (k == 0) begin
			o.v_value = 2 % n;
			return o;
		end
		pm = mreduce(p, n); qm = mreduce(q, n);
		uh = 1 % n; vl = 2 % n; vh = pm; ql = 1 % n; qh = 1 % n;
		top = 63;
		while (!k[top]) top--;
		tz = 0;
		while (!k[tz]) tz++;
		for (j = top; j >= tz + 1; j--) begin
			ql = mmul(ql, qh, n);
			if (k[j]) begin
				qh = mmul(ql, qm, n);
				uh = mmul(uh, vh, n);
				vl = msub(mmul(vh, vl, n), mmul(ql, pm, n), n);
				t = madd(qh, qh, n);
				vh = msub(mmul(vh, vh, n), t, n);
			end else begin
				qh = ql;
				uh = msub(mmul(uh, vl, n), ql, n);
				vh = msub(mmul(vh, vl, n), mmul(ql, pm, n), n);
				t = madd(ql, ql, n);
				vl = msub(mmul(vl, vl, n), t, n);
			end
		end
		// combining step, then one squaring per trailing zero of k
		ql = mmul(ql, qh, n);
		qh = mmul(ql, qm, n);
		uh = msub(mmul(uh, vl, n), ql, n);
		vl = msub(mmul(vh, vl, n), mmul(ql, pm, n), n);
		ql = mmul(ql, qh, n);
		for (j = 1; j <= tz; j++) begin
			uh = mmul(uh, vl, n);
			t = madd(ql, ql, n);
			vl = msub(mmul(vl, vl, n), t, n);
			ql = mmul(ql, ql, n);
		end
		o.u_value = uh;
		o.v_value = vl;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	// send one request; random idle gaps unless calm. start stays high after
	// acceptance so the next request can follow at once
	task automatic send_request(logic [63:0] p, q, k, n);
		req_t r;
		r.coef_p = p; r.coef_q = q; r.seq_index = k; r.modulus = n;
		while (!calm && $urandom_range(99) < 19) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		lucas_due.push_back(lucas_predict(r));
	endtask

	// check each result strobe
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (lucas_due.size() == 0) begin
				report_mismatch("unexpected result", res.u_value, 64'd0);
			end else begin
				want = lucas_due.pop_front();
				if (res.u_value !== want.u_value)
					report_mismatch("u_value", res.u_value, want.u_value);
				if (res.v_value !== want.v_value)
					report_mismatch("v_value", res.v_value, want.v_value);
				if (res.status !== want.status)
					report_mismatch("status", 64'(res.status), 64'(want.status));
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCH_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// short indices keep the ladder fast; moduli are small or random
	function automatic logic [63:0] rand_index();
		logic [63:0] k;
		k = {$urandom, $urandom};
		case ($urandom_range(3))
			0: k = k & 64'hF;
			1: k = k & 64'hFF;
			2: k = k & 64'hFFF;
			default: k = k;
		endcase
		return k;
	endfunction

	function automatic logic [63:0] rand_modulus();
		case ($urandom_range(3))
			0: return 64'($urandom_range(1, 50));
			1: return 64'($urandom);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic test_errors();
		send_request(64'd4, 64'd4, 64'd5, 64'd97);     // P*P == 4Q
		send_request(-64'sd6, 64'd9, 64'd0, 64'd0);    // both errors, disc wins
		send_request(64'd3, 64'd1, 64'd7, 64'd0);      // zero modulus
		send_request(64'h8000_0000_0000_0000, 64'd0, 64'd3, 64'd11);
		send_request(64'd0, 64'd0, 64'd3, 64'd11);     // 0*0 == 4*0
		send_request(64'h0000_0001_FFFF_FFFE, 64'hFFFF_FFFE_0000_0001, 64'd3, 64'd13);
	endtask

	task automatic test_edges();
		send_request(64'd1, -64'sd1, 64'd0, 64'd100);  // index zero
		send_request(64'd1, -64'sd1, 64'd0, 64'd1);
		send_request(64'd1, -64'sd1, 64'd0, 64'd2);
		send_request(64'd1, -64'sd1, 64'd10, 64'd1000); // Fibonacci
		send_request(64'd3, 64'd2, 64'd7, 64'd1);       // modulus one
		send_request(64'd3, 64'd2, 64'd16, 64'd1000003);
		send_request(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'd5, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
			64'd6, 64'hFFFF_FFFF_FFFF_FFC5);
		send_request(-64'sd1, -64'sd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(64'd5, 64'd3, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
		send_request(64'd2, 64'd7, 64'd1, 64'd9);
	endtask

	task automatic test_random(int count);
		logic [63:0] p, q;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 3) && (i < count / 2);
			p = {$urandom, $urandom};
			q = {$urandom, $urandom};
			if ($urandom_range(3) == 0) begin
				p = 64'($signed($urandom_range(40)) - 20);
				q = 64'($signed($urandom_range(40)) - 20);
			end
			if ($urandom_range(19) == 0) q = 64'd0;
			send_request(p, q, rand_index(), rand_modulus());
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_errors();
		test_edges();
		test_random(100);
		start <= 1'b0;
		while (lucas_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end
endmodule
`default_nettype wire
